[hdl/atpr_pkg.sv]
package atpr_pkg;

    localparam int ANGLE_ITERATIONS = 18;
    localparam int TABLE_LEN        = 24;
    localparam int CORDIC_STAGES    = (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS
                                                                      : TABLE_LEN;
    localparam int SQRT_STAGES      = 32;
    localparam int XY_W             = 36;
    localparam int Z_W              = 28;
    localparam int FRAC_BITS        = 16;
    localparam logic signed [Z_W-1:0] MAX_Z = Z_W'(900 * 65536);

    // per-axis data while the floor square root is being built
    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
        logic [16:0] amag;
        logic        neg;
        logic        zero;
    } t_sq_ch;

    typedef struct packed {
        logic              valid;
        t_sq_ch [1:0]      ch;
    } t_sq;

    // per-axis data during the vectoring rotations
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
        logic                   zero;
    } t_cd_ch;

    typedef struct packed {
        logic              valid;
        t_cd_ch [1:0]      ch;
    } t_cd;

    // atan(2^-i) in units of 2^-16 tenth-degree
    function automatic logic signed [Z_W-1:0] atan_tab(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = Z_W'(29491200);
            5'd1:  v = Z_W'(17409672);
            5'd2:  v = Z_W'(9198793);
            5'd3:  v = Z_W'(4669451);
            5'd4:  v = Z_W'(2343786);
            5'd5:  v = Z_W'(1173036);
            5'd6:  v = Z_W'(586661);
            5'd7:  v = Z_W'(293348);
            5'd8:  v = Z_W'(146676);
            5'd9:  v = Z_W'(73339);
            5'd10: v = Z_W'(36669);
            5'd11: v = Z_W'(18335);
            5'd12: v = Z_W'(9167);
            5'd13: v = Z_W'(4584);
            5'd14: v = Z_W'(2292);
            5'd15: v = Z_W'(1146);
            5'd16: v = Z_W'(573);
            5'd17: v = Z_W'(286);
            5'd18: v = Z_W'(143);
            5'd19: v = Z_W'(72);
            5'd20: v = Z_W'(36);
            5'd21: v = Z_W'(18);
            5'd22: v = Z_W'(9);
            5'd23: v = Z_W'(4);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/atpr_sqrt_cell.sv]
module atpr_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  atpr_pkg::t_sq  i_d,
    output atpr_pkg::t_sq  o_d
);

    atpr_pkg::t_sq r_d;
    atpr_pkg::t_sq n_d;

    // one root bit per cell, restoring form
    always_comb begin
        logic [34:0] rem2;
        logic [34:0] trial;
        logic        ge;
        n_d = i_d;
        for (int k = 0; k < 2; k++) begin
            rem2  = {i_d.ch[k].rem[32:0], i_d.ch[k].rad[63:62]};
            trial = {1'b0, i_d.ch[k].root, 2'b01};
            ge    = (rem2 >= trial);
            n_d.ch[k].rem  = ge ? (rem2 - trial) : rem2;
            n_d.ch[k].root = {i_d.ch[k].root[30:0], ge};
            n_d.ch[k].rad  = {i_d.ch[k].rad[61:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d.valid <= n_d.valid;
        end
        if (i_en) begin
            r_d.ch <= n_d.ch;
        end
    end

    assign o_d = r_d;

endmodule

[hdl/atpr_cordic_cell.sv]
module atpr_cordic_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [4:0]     i_iter,
    input  atpr_pkg::t_cd  i_d,
    output atpr_pkg::t_cd  o_d
);

    atpr_pkg::t_cd r_d;
    atpr_pkg::t_cd n_d;

    // one micro-rotation, driving y toward zero
    always_comb begin
        logic signed [atpr_pkg::XY_W-1:0] xs;
        logic signed [atpr_pkg::XY_W-1:0] ys;
        logic signed [atpr_pkg::Z_W-1:0]  t;
        n_d = i_d;
        t   = atpr_pkg::atan_tab(i_iter);
        for (int k = 0; k < 2; k++) begin
            xs = i_d.ch[k].x >>> i_iter;
            ys = i_d.ch[k].y >>> i_iter;
            if (!i_d.ch[k].y[atpr_pkg::XY_W-1]) begin
                n_d.ch[k].x = i_d.ch[k].x + ys;
                n_d.ch[k].y = i_d.ch[k].y - xs;
                n_d.ch[k].z = i_d.ch[k].z + t;
            end else begin
                n_d.ch[k].x = i_d.ch[k].x - ys;
                n_d.ch[k].y = i_d.ch[k].y + xs;
                n_d.ch[k].z = i_d.ch[k].z - t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d.valid <= n_d.valid;
        end
        if (i_en) begin
            r_d.ch <= n_d.ch;
        end
    end

    assign o_d = r_d;

endmodule

[hdl/accel_tilt_pitch_roll.sv]
// accelerometer tilt: for each sample word (x, y, z) the block returns pitch =
// atan2(x, sqrt(y^2+z^2)) and roll = atan2(y, sqrt(x^2+z^2)) in tenths of a
// degree, truncated toward zero, range -900..900; a zero numerator gives 0.
// one word is taken every cycle unless the chain holds, and results come out in
// order through one stage of squaring, 32 square root cells (one root bit each,
// magnitude in q.16), 18 cordic vectoring cells and one output stage. the whole
// chain advances together; it holds while a result waits on the master side.
module accel_tilt_pitch_roll (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // pitch_tenths[10:0], roll_tenths[21:11], zero pad
);

    localparam int NS = atpr_pkg::SQRT_STAGES;
    localparam int NC = atpr_pkg::CORDIC_STAGES;

    // whole chain steps when the output register is empty or being drained
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // squaring stage
    logic               r_sq_valid;
    logic [30:0]        r_x2, r_y2, r_z2;
    logic signed [15:0] r_ax, r_ay;
    logic signed [15:0] ax, ay, az;
    logic signed [31:0] px, py, pz;

    assign ax = i_s_tdata[15:0];
    assign ay = i_s_tdata[31:16];
    assign az = i_s_tdata[47:32];
    assign px = ax * ax;
    assign py = ay * ay;
    assign pz = az * az;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else if (en) begin
            r_sq_valid <= i_s_tvalid;
        end
        if (en) begin
            r_x2 <= px[30:0];
            r_y2 <= py[30:0];
            r_z2 <= pz[30:0];
            r_ax <= ax;
            r_ay <= ay;
        end
    end

    // square root chain, channel 0 is pitch (numerator x), channel 1 is roll
    atpr_pkg::t_sq sq [NS+1];
    logic [31:0]   s_p, s_r;
    logic [16:0]   mag_x, mag_y;

    assign s_p   = {1'b0, r_y2} + {1'b0, r_z2};
    assign s_r   = {1'b0, r_x2} + {1'b0, r_z2};
    assign mag_x = r_ax[15] ? (17'd0 - {r_ax[15], r_ax}) : {1'b0, r_ax};
    assign mag_y = r_ay[15] ? (17'd0 - {r_ay[15], r_ay}) : {1'b0, r_ay};

    always_comb begin
        sq[0].valid      = r_sq_valid;
        sq[0].ch[0].rem  = '0;
        sq[0].ch[0].root = '0;
        sq[0].ch[0].rad  = {s_p, 32'd0};
        sq[0].ch[0].amag = mag_x;
        sq[0].ch[0].neg  = r_ax[15];
        sq[0].ch[0].zero = (r_ax == '0);
        sq[0].ch[1].rem  = '0;
        sq[0].ch[1].root = '0;
        sq[0].ch[1].rad  = {s_r, 32'd0};
        sq[0].ch[1].amag = mag_y;
        sq[0].ch[1].neg  = r_ay[15];
        sq[0].ch[1].zero = (r_ay == '0);
    end

    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        atpr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (sq[g]),
            .o_d     (sq[g+1])
        );
    end

    // cordic chain: x starts at the magnitude, y at |numerator| in q.16
    atpr_pkg::t_cd cd [NC+1];

    always_comb begin
        cd[0].valid = sq[NS].valid;
        for (int k = 0; k < 2; k++) begin
            cd[0].ch[k].x    = {{(atpr_pkg::XY_W-32){1'b0}}, sq[NS].ch[k].root};
            cd[0].ch[k].y    = {{(atpr_pkg::XY_W-17-atpr_pkg::FRAC_BITS){1'b0}},
                                sq[NS].ch[k].amag, {atpr_pkg::FRAC_BITS{1'b0}}};
            cd[0].ch[k].z    = '0;
            cd[0].ch[k].neg  = sq[NS].ch[k].neg;
            cd[0].ch[k].zero = sq[NS].ch[k].zero;
        end
    end

    for (genvar g = 0; g < NC; g++) begin : g_cordic
        atpr_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_iter  (5'(g)),
            .i_d     (cd[g]),
            .o_d     (cd[g+1])
        );
    end

    // clamp, take the integer tenths and restore the sign
    logic [10:0] ang [2];

    always_comb begin
        logic signed [atpr_pkg::Z_W-1:0] zc;
        logic [10:0]                     m;
        for (int k = 0; k < 2; k++) begin
            zc = cd[NC].ch[k].z;
            if (zc[atpr_pkg::Z_W-1]) begin
                zc = '0;
            end else if (zc > atpr_pkg::MAX_Z) begin
                zc = atpr_pkg::MAX_Z;
            end
            m = {1'b0, zc[atpr_pkg::FRAC_BITS+9:atpr_pkg::FRAC_BITS]};
            if (cd[NC].ch[k].zero) begin
                ang[k] = '0;
            end else if (cd[NC].ch[k].neg) begin
                ang[k] = 11'd0 - m;
            end else begin
                ang[k] = m;
            end
        end
    end

    // output register
    logic        r_out_valid;
    logic [10:0] r_pitch, r_roll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= cd[NC].valid;
        end
        if (en) begin
            r_pitch <= ang[0];
            r_roll  <= ang[1];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_roll, r_pitch};

endmodule
